// ===== sv/flol_pkg.sv =====
package flol_pkg;

  localparam int DEPTH       = 16;
  localparam int KEY_WIDTH   = 32;
  localparam int COUNT_WIDTH = 16;
  localparam int IDX_W       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LEN_W       = $clog2(DEPTH + 1);
  localparam int POS_W       = 5;

  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

  typedef struct packed {
    logic                        cmd;
    logic signed [KEY_WIDTH-1:0] key;
  } in_item_t;

  typedef struct packed {
    logic [POS_W-1:0]       position;
    logic                   found;
    logic [COUNT_WIDTH-1:0] hit_count;
    logic                   full_error;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_UPD
  } flol_state_t;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic [KEY_WIDTH-1:0]   key;      // key of the item in flight
    logic [COUNT_WIDTH-1:0] count;    // hit entry's count after increment
    logic [KEY_WIDTH-1:0]   hit_key;  // key of the hit entry
    logic [KEY_WIDTH-1:0]   tgt_key;  // key of the swap target
    logic [COUNT_WIDTH-1:0] tgt_cnt;  // count of the swap target
    logic                   any_tgt;  // some earlier entry has a lower count
    logic                   cmp_en;   // compare phase
    logic                   upd_en;   // commit a lookup hit
    logic                   load_en;  // commit an append
  } flol_bc_t;

  function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] c);
    sat_inc = (c == COUNT_MAX) ? c : c + 1'b1;
  endfunction

endpackage

// ===== sv/flol_cell.sv =====
module flol_cell (
  input  logic                                clk,
  input  logic                                rst_n,
  input  flol_pkg::flol_bc_t                  bc,
  input  logic                                in_list,   // entry holds a key
  input  logic                                is_tail,   // first free slot
  input  logic                                seen_in,   // match seen to the left
  output logic                                seen_out,
  input  logic                                hleft_in,  // hit entry lies to the left
  output logic                                hleft_out,
  input  logic                                low_in,    // target found to the left
  output logic                                low_out,
  output logic                                hit_now,
  output logic [flol_pkg::KEY_WIDTH-1:0]      m_key,
  output logic [flol_pkg::COUNT_WIDTH-1:0]    m_cnt,
  output logic [flol_pkg::KEY_WIDTH-1:0]      t_key,
  output logic [flol_pkg::COUNT_WIDTH-1:0]    t_cnt
);
  import flol_pkg::*;

  logic [KEY_WIDTH-1:0]   key_r, key_nxt;
  logic [COUNT_WIDTH-1:0] cnt_r, cnt_nxt;
  logic                   hit_r;
  logic                   eq, lower, tgt;

  always_comb begin
    eq       = in_list && (key_r == bc.key);
    hit_now  = eq && !seen_in;
    seen_out = seen_in || eq;
    m_key    = hit_now ? key_r : '0;
    m_cnt    = hit_now ? cnt_r : '0;

    // only entries ahead of the hit may take its place
    hleft_out = hleft_in || hit_r;
    lower     = !hleft_in && !hit_r && in_list && (cnt_r < bc.count);
    tgt       = lower && !low_in;
    low_out   = low_in || lower;
    t_key     = tgt ? key_r : '0;
    t_cnt     = tgt ? cnt_r : '0;

    key_nxt = key_r;
    cnt_nxt = cnt_r;
    if (bc.upd_en) begin
      if (tgt) begin
        key_nxt = bc.hit_key;
        cnt_nxt = bc.count;
      end else if (hit_r) begin
        if (bc.any_tgt) begin
          key_nxt = bc.tgt_key;
          cnt_nxt = bc.tgt_cnt;
        end else begin
          cnt_nxt = bc.count;
        end
      end
    end
    if (bc.load_en && is_tail) begin
      key_nxt = bc.key;
      cnt_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    cnt_r <= cnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r <= 1'b0;
    end else if (bc.cmp_en) begin
      hit_r <= hit_now;
    end
  end

endmodule

// ===== sv/frequency_ordered_lookup_list.sv =====
// Frequency-ordered lookup list.
// Input channel (in_valid/in_ready/in_item): cmd selects append (load) or
// lookup of in_item.key. Result channel (out_valid/out_ready/out_item): one
// result per item, in order.
// The list lives in a row of DEPTH cells, each holding one key and its hit
// count. After acceptance a lookup goes through a compare cycle in which
// every cell checks its key and a first-match chain picks the hit, then an
// update cycle in which a first-lower chain picks the swap target and the
// two cells trade contents (with no target, the hit cell takes the new count).
// Loads use the same compare and update cycles. No item is accepted during
// a compare cycle; the next is accepted in the same cycle as the previous
// one's update. The result is registered and appears in the cycle after it.
// If out_ready is low while a result is still held, the update cycle waits,
// so in_ready drops until the held result is taken.
// Reset (rst_n low, synchronous) empties the list and drops out_valid; the
// cell contents are not cleared, only the length.
module frequency_ordered_lookup_list (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  flol_pkg::in_item_t   in_item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output flol_pkg::out_item_t  out_item
);
  import flol_pkg::*;

  flol_state_t state_r, state_nxt;

  logic                   cmd_r;
  logic [KEY_WIDTH-1:0]   key_r;
  logic [LEN_W-1:0]       len_r;
  logic                   found_r;
  logic [IDX_W-1:0]       hit_idx_r;
  logic [KEY_WIDTH-1:0]   hit_key_r;
  logic [COUNT_WIDTH-1:0] cnew_r;
  logic                   out_valid_r;
  out_item_t              out_r, out_nxt;

  logic in_acc, out_free, done, full;

  flol_bc_t bc;

  // neighbor chains through the cell row
  logic [DEPTH:0] seen_c, hleft_c, low_c;
  logic [DEPTH-1:0] hit_now;
  logic [KEY_WIDTH-1:0]   m_key [DEPTH];
  logic [COUNT_WIDTH-1:0] m_cnt [DEPTH];
  logic [KEY_WIDTH-1:0]   t_key [DEPTH];
  logic [COUNT_WIDTH-1:0] t_cnt [DEPTH];

  logic [KEY_WIDTH-1:0]   m_key_or, t_key_or;
  logic [COUNT_WIDTH-1:0] m_cnt_or, t_cnt_or;
  logic [IDX_W-1:0]       hit_idx;

  assign seen_c[0]  = 1'b0;
  assign hleft_c[0] = 1'b0;
  assign low_c[0]   = 1'b0;

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      flol_cell u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .bc        (bc),
        .in_list   (len_r > LEN_W'(gi)),
        .is_tail   (len_r == LEN_W'(gi)),
        .seen_in   (seen_c[gi]),
        .seen_out  (seen_c[gi+1]),
        .hleft_in  (hleft_c[gi]),
        .hleft_out (hleft_c[gi+1]),
        .low_in    (low_c[gi]),
        .low_out   (low_c[gi+1]),
        .hit_now   (hit_now[gi]),
        .m_key     (m_key[gi]),
        .m_cnt     (m_cnt[gi]),
        .t_key     (t_key[gi]),
        .t_cnt     (t_cnt[gi])
      );
    end
  endgenerate

  // at most one cell drives each bus, so a plain OR gathers it
  always_comb begin
    m_key_or = '0;
    m_cnt_or = '0;
    t_key_or = '0;
    t_cnt_or = '0;
    hit_idx  = '0;
    for (int i = 0; i < DEPTH; i++) begin
      m_key_or = m_key_or | m_key[i];
      m_cnt_or = m_cnt_or | m_cnt[i];
      t_key_or = t_key_or | t_key[i];
      t_cnt_or = t_cnt_or | t_cnt[i];
      if (hit_now[i]) begin
        hit_idx = hit_idx | IDX_W'(i);
      end
    end
  end

  assign full     = (len_r == LEN_W'(DEPTH));
  assign out_free = !out_valid_r || out_ready;
  assign done     = (state_r == ST_UPD) && out_free;
  assign in_ready = (state_r == ST_IDLE) || done;
  assign in_acc   = in_valid && in_ready;

  always_comb begin
    bc.key     = key_r;
    bc.count   = cnew_r;
    bc.hit_key = hit_key_r;
    bc.tgt_key = t_key_or;
    bc.tgt_cnt = t_cnt_or;
    bc.any_tgt = low_c[DEPTH];
    bc.cmp_en  = (state_r == ST_CMP);
    bc.upd_en  = done && (cmd_r == CMD_LOOKUP) && found_r;
    bc.load_en = done && (cmd_r == CMD_LOAD) && !full;
  end

  // next state and result formatting
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ST_CMP;
        end
      end
      ST_CMP: begin
        state_nxt = ST_UPD;
      end
      ST_UPD: begin
        if (in_acc) begin
          state_nxt = ST_CMP;
        end else if (done) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    out_nxt = '0;
    if (cmd_r == CMD_LOOKUP) begin
      if (found_r) begin
        out_nxt.position  = POS_W'({1'b0, hit_idx_r} + 1'b1);
        out_nxt.found     = 1'b1;
        out_nxt.hit_count = cnew_r;
      end else begin
        out_nxt.position  = POS_W'({1'b0, len_r} + 1'b1);
      end
    end else if (full) begin
      out_nxt.full_error = 1'b1;
    end else begin
      out_nxt.position = POS_W'({1'b0, len_r} + 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      len_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (bc.load_en) begin
        len_r <= len_r + 1'b1;
      end
      if (done) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r <= in_item.cmd;
      key_r <= in_item.key;
    end
    if (state_r == ST_CMP) begin
      found_r   <= seen_c[DEPTH];
      hit_idx_r <= hit_idx;
      hit_key_r <= m_key_or;
      cnew_r    <= sat_inc(m_cnt_or);
    end
    if (done) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

// ===== verif/flol_checker.sv =====
`timescale 1ns / 100ps
module flol_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  flol_pkg::in_item_t  in_item,
  input  logic                out_valid,
  input  logic                out_ready,
  input  flol_pkg::out_item_t out_item,
  output int                  fail_total,
  output int                  awaited,
  output int                  hit_total,
  output int                  move_total,
  output int                  ceiling_total,
  output int                  miss_total,
  output int                  refused_total
);
  import flol_pkg::*;

  // shadow of the list, kept in list order
  logic [KEY_WIDTH-1:0]   shelf_key   [DEPTH];
  logic [COUNT_WIDTH-1:0] shelf_count [DEPTH];
  int                     shelf_len;
  out_item_t              awaited_answers [$];
  out_item_t              want;
  out_item_t              made;

  task automatic apply_item(input in_item_t it, output out_item_t ans);
    int                     hit;
    int                     i;
    bit                     moved;
    logic [COUNT_WIDTH-1:0] c;
    logic [KEY_WIDTH-1:0]   tk;
    logic [COUNT_WIDTH-1:0] tc;
    ans   = '0;
    hit   = -1;
    moved = 1'b0;
    if (it.cmd == CMD_LOAD) begin
      if (shelf_len >= DEPTH) begin
        ans.full_error = 1'b1;
        refused_total++;
      end else begin
        shelf_key[shelf_len]   = it.key;
        shelf_count[shelf_len] = '0;
        shelf_len++;
        ans.position = POS_W'(shelf_len);
      end
    end else begin
      for (i = 0; i < shelf_len && hit < 0; i++)
        if (shelf_key[i] == it.key) hit = i;
      if (hit < 0) begin
        ans.position = POS_W'(shelf_len + 1);
        miss_total++;
      end else begin
        c = shelf_count[hit];
        if (c == COUNT_MAX) ceiling_total++;
        else c = c + 1'b1;
        shelf_count[hit] = c;
        ans.position  = POS_W'(hit + 1);
        ans.found     = 1'b1;
        ans.hit_count = c;
        hit_total++;
        // trade places with the first earlier entry now counted lower
        for (i = 0; i < hit && !moved; i++) begin
          if (shelf_count[i] < c) begin
            tk               = shelf_key[i];
            tc               = shelf_count[i];
            shelf_key[i]     = shelf_key[hit];
            shelf_count[i]   = c;
            shelf_key[hit]   = tk;
            shelf_count[hit] = tc;
            moved            = 1'b1;
            move_total++;
          end
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      shelf_len = 0;
      awaited_answers.delete();
      awaited = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (awaited_answers.size() == 0) begin
          fail_total++;
          if (fail_total <= 10)
            $display("checker: %0t unexpected result pos=%0d found=%0b cnt=%0d full=%0b",
                     $time, out_item.position, out_item.found, out_item.hit_count,
                     out_item.full_error);
        end else begin
          want = awaited_answers.pop_front();
          if (out_item.position !== want.position || out_item.found !== want.found ||
              out_item.hit_count !== want.hit_count ||
              out_item.full_error !== want.full_error) begin
            fail_total++;
            // fields: position/found/hit_count/full_error
            if (fail_total <= 10)
              $display("checker: %0t mismatch exp %0d/%0b/%0d/%0b got %0d/%0b/%0d/%0b",
                       $time, want.position, want.found, want.hit_count, want.full_error,
                       out_item.position, out_item.found, out_item.hit_count,
                       out_item.full_error);
          end
        end
      end
      if (in_valid && in_ready) begin
        apply_item(in_item, made);
        awaited_answers.push_back(made);
      end
      awaited = awaited_answers.size();
    end
  end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps
module testbench;
  import flol_pkg::*;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_item   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;

  int fail_total, awaited;
  int hit_total, move_total, ceiling_total, miss_total, refused_total;

  // steady: no idling on either side; squeeze: ask the sink for one long hold
  bit steady  = 1'b0;
  bit squeeze = 1'b0;

  // keys the list has taken so far; lets the sender aim lookups at real entries
  logic [KEY_WIDTH-1:0] stocked [$];

  always #5 clk = ~clk;

  frequency_ordered_lookup_list dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  flol_checker watcher (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_item       (in_item),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_item      (out_item),
    .fail_total    (fail_total),
    .awaited       (awaited),
    .hit_total     (hit_total),
    .move_total    (move_total),
    .ceiling_total (ceiling_total),
    .miss_total    (miss_total),
    .refused_total (refused_total)
  );

  // mostly back-to-back, often a short pause, now and then a long one
  function automatic int idle_span();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Called and returns at a falling edge. Valid stays up across back-to-back
  // items, so it is only lowered when a gap is actually taken.
  task automatic offer(input logic op, input logic [KEY_WIDTH-1:0] k);
    int gap;
    gap = steady ? 0 : idle_span();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_item  <= '{cmd: op, key: k};
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    if (op == CMD_LOAD && stocked.size() < DEPTH) stocked.push_back(k);
  endtask

  // Result side: random stalls, plus one long hold on request so the block
  // backs up and drops in_ready while the sender keeps pushing.
  initial begin : sink
    int stall_left;
    bit squeezed;
    stall_left = 0;
    squeezed   = 1'b0;
    forever begin
      @(negedge clk);
      if (squeeze && !squeezed) begin
        squeezed   = 1'b1;
        stall_left = 400;
      end else if (stall_left == 0 && !steady && $urandom_range(0, 3) == 0) begin
        stall_left = idle_span();
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    int                   i;
    int                   n;
    int                   pick;
    int                   idx;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // lookup on an empty list misses at position 1
    offer(CMD_LOOKUP, 32'h0000_0000);
    // key extremes, plus a duplicate of the largest key
    offer(CMD_LOAD, 32'h8000_0000);
    offer(CMD_LOAD, 32'h7FFF_FFFF);
    offer(CMD_LOAD, 32'h0000_0000);
    offer(CMD_LOAD, 32'hFFFF_FFFF);
    offer(CMD_LOAD, 32'h7FFF_FFFF);
    // first copy of the duplicate is the hit; it moves ahead of a zero count
    offer(CMD_LOOKUP, 32'h7FFF_FFFF);
    offer(CMD_LOOKUP, 32'h7FFF_FFFF);
    // hit from the tail region, swaps past several zero counts
    offer(CMD_LOOKUP, 32'hFFFF_FFFF);
    // equal count ahead: no swap; one more hit and it overtakes
    offer(CMD_LOOKUP, 32'hFFFF_FFFF);
    offer(CMD_LOOKUP, 32'hFFFF_FFFF);
    // misses: unknown key, and one bit away from a stored key; then a hit on that stored key
    offer(CMD_LOOKUP, 32'h0000_0001);
    offer(CMD_LOOKUP, 32'h8000_0001);
    offer(CMD_LOOKUP, 32'h8000_0000);
    // fill the list with walking ones, then one load too many
    for (i = 0; i < 11; i++) offer(CMD_LOAD, 32'h1 << (i * 3));
    offer(CMD_LOAD, 32'h5A5A_A5A5);

    // Random traffic: mostly lookups of stored keys (skewed toward the head
    // so counts spread out and entries keep reordering), some random-key
    // misses, and a few loads that the full list refuses.
    for (n = 0; n < 1200; n++) begin
      if (n == 400) begin
        steady  = 1'b1;
        squeeze = 1'b1;
      end
      if (n == 440) steady = 1'b0;
      pick = $urandom_range(0, 99);
      if (pick < 72) begin
        idx = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 3)
                                          : $urandom_range(0, stocked.size() - 1);
        offer(CMD_LOOKUP, stocked[idx]);
      end else if (pick < 88) begin
        offer(CMD_LOOKUP, $urandom());
      end else begin
        offer(CMD_LOAD, $urandom());
      end
    end
    in_valid <= 1'b0;

    // drain, then a few cycles for anything stray
    while (awaited != 0) @(negedge clk);
    repeat (10) @(negedge clk);

    $display("covered %0d lookup hits (%0d moved up, %0d at the count ceiling), %0d misses",
             hit_total, move_total, ceiling_total, miss_total);
    $display("refused loads into a full list: %0d, mismatches: %0d",
             refused_total, fail_total);
    if (fail_total == 0 && awaited == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // hard stop, several times the slowest legal run
  initial begin : watchdog
    #60_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
